[rtl/tlas_pkg.sv]
package tlas_pkg;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_STEP  = 2'd2;

  localparam int MIN_SIDE = 3;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  localparam logic [12:0] POP_MAX = 13'h1FFF;

  typedef struct packed {
    logic       alive_in;
    logic [5:0] col;
    logic [5:0] row;
  } req_word_t;

  typedef struct packed {
    logic [31:0] generation;
    logic [12:0] population;
    logic        cell_state;
  } result_t;

endpackage

[rtl/toroidal_life_automaton_step.sv]
// Toroidal life automaton (rule B3/S23) held in a row-wide grid memory.
// Requests arrive on the s_axis channel: tuser carries the request kind
// (write a cell, read a cell, advance one generation) and tdata carries the
// cell address and the value to write. Every request produces exactly one
// word on the m_axis channel with the read cell, the population after the
// latest generation and the generation count.
// The result of a cell write or read passes through the ACCESS and DONE states; a request
// whose address lies outside the active side or whose request kind is unused goes straight to DONE.
// A generation step walks the active side s one cell per cycle over rows
// held in three row registers, with the memory read and a PREP state before
// each row's cells and the write-back in ROWEND after them. One request is
// worked on at a time; the next one is accepted as soon as the current
// result is loaded into the output register.
// The user must write the side length on cfg_we/cfg_wdata only while no request
// is open; the block itself does not enforce it. After reset the block clears
// the grid memory one row per cycle and accepts no request until it is done.
// While the receiver stalls, the finished word waits in the output
// register and a new request can still be accepted and worked on.
module toroidal_life_automaton_step #(
  parameter int MAX_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // row[5:0], col[11:6], alive_in[12]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // cell_state[0], population[13:1], generation[45:14]
);
  import tlas_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > 7) ? SIDE_W : 7;

  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_ACCESS    = 4'd2;
  localparam logic [3:0] ST_LOAD_PREV = 4'd3;
  localparam logic [3:0] ST_LOAD_CUR  = 4'd4;
  localparam logic [3:0] ST_LOAD_NXT  = 4'd5;
  localparam logic [3:0] ST_PREP      = 4'd6;
  localparam logic [3:0] ST_CELLS     = 4'd7;
  localparam logic [3:0] ST_ROWEND    = 4'd8;
  localparam logic [3:0] ST_DONE      = 4'd9;

  logic [MAX_SIDE-1:0] grid_mem [MAX_SIDE];

  logic [3:0]          state;
  logic [6:0]          grid_side;
  logic [IDX_W-1:0]    clr_cnt;
  logic [IDX_W-1:0]    row_cnt;
  logic [IDX_W-1:0]    col_cnt;
  logic [IDX_W-1:0]    col_left;
  logic [IDX_W-1:0]    col_right;
  logic [12:0]         pop_acc;
  logic [12:0]         living_count;
  logic [31:0]         generation_count;

  logic [1:0]          req;
  logic [IDX_W-1:0]    req_row;
  logic [IDX_W-1:0]    req_col;
  logic                req_alive;
  logic                cell_bit;
  logic [MAX_SIDE-1:0] prev_row;
  logic [MAX_SIDE-1:0] cur_row;
  logic [MAX_SIDE-1:0] nxt_row;
  logic [MAX_SIDE-1:0] row0_orig;
  logic [MAX_SIDE-1:0] res_row;
  logic [MAX_SIDE-1:0] mem_rdata;
  result_t             out_word;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [MAX_SIDE-1:0] mem_wdata;
  logic                mem_re;
  logic [IDX_W-1:0]    mem_raddr;

  logic [CMP_W-1:0]    side_ext;
  logic [CMP_W-1:0]    side_full;
  logic [SIDE_W-1:0]   side;
  logic [IDX_W-1:0]    last;
  logic                in_accept;
  logic                out_load;
  req_word_t           in_word;
  logic                in_area;
  logic [3:0]          n_cnt;
  logic                new_bit;

  assign in_word       = req_word_t'(s_axis_tdata[12:0]);
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign m_axis_tdata  = {2'b00, out_word};

  always_comb begin
    side_ext = CMP_W'(grid_side);
    if (side_ext < CMP_W'(MIN_SIDE)) begin
      side_full = CMP_W'(MIN_SIDE);
    end else if (side_ext > CMP_W'(MAX_SIDE)) begin
      side_full = CMP_W'(MAX_SIDE);
    end else begin
      side_full = side_ext;
    end
    side    = SIDE_W'(side_full);
    last    = IDX_W'(side - SIDE_W'(1));
    in_area = (CMP_W'(in_word.row) < side_full) && (CMP_W'(in_word.col) < side_full);
  end

  always_comb begin
    n_cnt = 4'(prev_row[col_left]) + 4'(prev_row[col_cnt]) + 4'(prev_row[col_right])
          + 4'(cur_row[col_left]) + 4'(cur_row[col_right])
          + 4'(nxt_row[col_left]) + 4'(nxt_row[col_cnt]) + 4'(nxt_row[col_right]);
    if (cur_row[col_cnt]) begin
      new_bit = (n_cnt == SURVIVE_LOW) || (n_cnt == BIRTH_COUNT);
    end else begin
      new_bit = (n_cnt == BIRTH_COUNT);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_cnt;
    mem_wdata = res_row;
    mem_re    = 1'b0;
    mem_raddr = IDX_W'(in_word.row);
    unique case (state) inside
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_re = in_accept;
        if (s_axis_tuser == REQ_STEP) begin
          mem_raddr = last;
        end
      end
      ST_ACCESS: begin
        mem_waddr          = req_row;
        mem_wdata          = mem_rdata;
        mem_wdata[req_col] = req_alive;
        mem_we             = (req == REQ_WRITE);
      end
      ST_LOAD_PREV: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      ST_LOAD_CUR: begin
        mem_re    = 1'b1;
        mem_raddr = IDX_W'(1);
      end
      ST_ROWEND: begin
        mem_we    = 1'b1;
        mem_raddr = row_cnt + IDX_W'(2);
        mem_re    = (row_cnt != last) && (row_cnt + IDX_W'(1) != last);
      end
      ST_LOAD_NXT, ST_PREP, ST_CELLS, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= grid_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      grid_side        <= 7'd64;
      clr_cnt          <= '0;
      row_cnt          <= '0;
      col_cnt          <= '0;
      col_left         <= '0;
      col_right        <= '0;
      pop_acc          <= '0;
      living_count     <= '0;
      generation_count <= '0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        grid_side <= cfg_wdata;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == IDX_W'(MAX_SIDE - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            row_cnt <= '0;
            pop_acc <= '0;
            case (s_axis_tuser) inside
              REQ_WRITE, REQ_READ: state <= in_area ? ST_ACCESS : ST_DONE;
              REQ_STEP:            state <= ST_LOAD_PREV;
              default:             state <= ST_DONE;
            endcase
          end
        end
        ST_ACCESS:    state <= ST_DONE;
        ST_LOAD_PREV: state <= ST_LOAD_CUR;
        ST_LOAD_CUR:  state <= ST_LOAD_NXT;
        ST_LOAD_NXT:  state <= ST_PREP;
        ST_PREP: begin
          col_cnt   <= '0;
          col_left  <= last;
          col_right <= IDX_W'(1);
          state     <= ST_CELLS;
        end
        ST_CELLS: begin
          if (new_bit && (pop_acc != POP_MAX)) begin
            pop_acc <= pop_acc + 13'd1;
          end
          col_left  <= col_cnt;
          col_cnt   <= col_cnt + IDX_W'(1);
          col_right <= (col_right == last) ? '0 : col_right + IDX_W'(1);
          if (col_cnt == last) begin
            state <= ST_ROWEND;
          end
        end
        ST_ROWEND: begin
          if (row_cnt == last) begin
            living_count     <= pop_acc;
            generation_count <= generation_count + 32'd1;
            state            <= ST_DONE;
          end else begin
            row_cnt <= row_cnt + IDX_W'(1);
            state   <= (row_cnt + IDX_W'(1) == last) ? ST_PREP : ST_LOAD_NXT;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        req       <= s_axis_tuser;
        req_row   <= IDX_W'(in_word.row);
        req_col   <= IDX_W'(in_word.col);
        req_alive <= in_word.alive_in;
        cell_bit  <= 1'b0;
      end
      ST_ACCESS: begin
        cell_bit <= (req == REQ_READ) ? mem_rdata[req_col] : 1'b0;
      end
      ST_LOAD_PREV: prev_row <= mem_rdata;
      ST_LOAD_CUR: begin
        cur_row   <= mem_rdata;
        row0_orig <= mem_rdata;
      end
      ST_LOAD_NXT: nxt_row <= mem_rdata;
      ST_PREP: res_row <= cur_row;
      ST_CELLS: res_row[col_cnt] <= new_bit;
      ST_ROWEND: begin
        prev_row <= cur_row;
        cur_row  <= nxt_row;
        if (row_cnt + IDX_W'(1) == last) begin
          nxt_row <= row0_orig;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_word.cell_state <= cell_bit;
          out_word.population <= living_count;
          out_word.generation <= generation_count;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("grid memory written while idle");

  a_no_same_row: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write of the same grid row in one cycle");

  a_gen_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROWEND && row_cnt == last) |=>
      (generation_count == $past(generation_count) + 32'd1))
    else $error("generation count did not advance at the end of a step");
`endif

endmodule
